### design/chunked_body_decoder_macros.svh
// Assertion macros shared by the chunked body decoder modules.
// Depends on nothing; define ASSERT_OFF to leave all assertions out.
`ifndef CHUNKED_BODY_DECODER_MACROS_SVH
`define CHUNKED_BODY_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
`define CBD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("chunked body decoder assertion failed");
`define CBD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  `CBD_ASSERT(lbl, clk, rstn, (ante) |-> (cons))
`define CBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `CBD_ASSERT(lbl, clk, rstn, (ante) |=> (cons))
`else
`define CBD_ASSERT(lbl, clk, rstn, prop)
`define CBD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### design/cbd_pkg.sv
// Types, character codes and phase codes for the chunked body decoder.
// Depends on nothing; used by cbd_core, cbd_out_buf and the top level.
package cbd_pkg;

  localparam logic [3:0] PH_SIZE    = 4'd0;
  localparam logic [3:0] PH_SIZE_LF = 4'd1;
  localparam logic [3:0] PH_EXT     = 4'd2;
  localparam logic [3:0] PH_EXT_CR  = 4'd3;
  localparam logic [3:0] PH_DATA    = 4'd4;
  localparam logic [3:0] PH_DATA_CR = 4'd5;
  localparam logic [3:0] PH_DATA_LF = 4'd6;
  localparam logic [3:0] PH_FIN_CR  = 4'd7;
  localparam logic [3:0] PH_FIN_LF  = 4'd8;
  localparam logic [3:0] PH_DONE    = 4'd9;
  localparam logic [3:0] PH_ERR     = 4'd10;

  localparam int FL_SIGN   = 0;
  localparam int FL_DIGIT  = 1;
  localparam int FL_ZERO   = 2;
  localparam int FL_PREFIX = 3;
  localparam int FL_TRAIL  = 4;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_XU   = 8'h58;
  localparam logic [7:0] CH_XL   = 8'h78;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       chunk_end;
    logic [1:0] status;
  } cbd_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } cbd_hex_t;

  function automatic cbd_hex_t hex_decode(input logic [7:0] c);
    cbd_hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

### design/chunked_body_decoder.sv
// Chunked transfer body decoder: one body byte per input beat, one result beat
// per input beat. The decoder takes one beat on every clock while the output
// side keeps up, and each result is registered in an output register backed
// by one skid entry. The rate is set by the parser state update, which handles
// one byte per cycle. Depends on cbd_pkg, cbd_core and cbd_out_buf.
module chunked_body_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] payload_byte
  output logic       out_tlast,  // chunk_end
  output logic [2:0] out_tuser   // [0] payload_valid, [2:1] status
);

  logic                 push;
  cbd_pkg::cbd_result_t step_res;
  cbd_pkg::cbd_result_t out_res;

  assign push = in_tvalid && in_tready;

  cbd_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .data_byte(in_tdata),
    .res      (step_res)
  );

  cbd_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (step_res),
    .can_push (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign out_tdata = out_res.payload_byte;
  assign out_tlast = out_res.chunk_end;
  assign out_tuser = {out_res.status, out_res.payload_valid};

endmodule

### design/cbd_core.sv
// Parser state and per-byte decode for the chunked body decoder.
// Depends on cbd_pkg and chunked_body_decoder_macros.svh.
`include "chunked_body_decoder_macros.svh"

module cbd_core #(
  parameter int SIZE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [7:0]          data_byte,
  output cbd_pkg::cbd_result_t res
);

  logic [3:0]           phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] count_r, count_nxt;
  logic [4:0]           flags_r, flags_nxt;
  cbd_pkg::cbd_hex_t    hex;
  logic                 is_blank;

  assign hex      = cbd_pkg::hex_decode(data_byte);
  assign is_blank = (data_byte == cbd_pkg::CH_SP) || (data_byte == cbd_pkg::CH_TAB);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    flags_nxt = flags_r;
    res.payload_byte  = 8'd0;
    res.payload_valid = 1'b0;
    res.chunk_end     = 1'b0;
    unique case (phase_r)
      cbd_pkg::PH_SIZE: begin
        if (is_blank) begin
          if (!(flags_r[cbd_pkg::FL_SIGN] || flags_r[cbd_pkg::FL_DIGIT] ||
                flags_r[cbd_pkg::FL_PREFIX])) begin
            phase_nxt = cbd_pkg::PH_SIZE;
          end else if (!flags_r[cbd_pkg::FL_DIGIT]) begin
            phase_nxt = cbd_pkg::PH_ERR;
          end else begin
            flags_nxt[cbd_pkg::FL_TRAIL] = 1'b1;
          end
        end else if (data_byte == cbd_pkg::CH_PLUS) begin
          if (flags_r == 5'd0) begin
            flags_nxt[cbd_pkg::FL_SIGN] = 1'b1;
          end else begin
            phase_nxt = cbd_pkg::PH_ERR;
          end
        end else if (hex.ok) begin
          if (flags_r[cbd_pkg::FL_TRAIL] || (count_r[SIZE_BITS-1 -: 4] != 4'd0)) begin
            phase_nxt = cbd_pkg::PH_ERR;
          end else begin
            count_nxt = {count_r[SIZE_BITS-5:0], hex.value};
            flags_nxt[cbd_pkg::FL_ZERO] = !flags_r[cbd_pkg::FL_DIGIT] &&
                                          !flags_r[cbd_pkg::FL_PREFIX] &&
                                          (hex.value == 4'd0);
            flags_nxt[cbd_pkg::FL_DIGIT]  = 1'b1;
            flags_nxt[cbd_pkg::FL_PREFIX] = 1'b0;
          end
        end else if ((data_byte == cbd_pkg::CH_XL) || (data_byte == cbd_pkg::CH_XU)) begin
          if (!flags_r[cbd_pkg::FL_ZERO] || flags_r[cbd_pkg::FL_TRAIL]) begin
            phase_nxt = cbd_pkg::PH_ERR;
          end else begin
            flags_nxt[cbd_pkg::FL_ZERO]   = 1'b0;
            flags_nxt[cbd_pkg::FL_DIGIT]  = 1'b0;
            flags_nxt[cbd_pkg::FL_PREFIX] = 1'b1;
          end
        end else if (data_byte == cbd_pkg::CH_SEMI) begin
          phase_nxt = flags_r[cbd_pkg::FL_DIGIT] ? cbd_pkg::PH_EXT : cbd_pkg::PH_ERR;
        end else if (data_byte == cbd_pkg::CH_CR) begin
          phase_nxt = flags_r[cbd_pkg::FL_DIGIT] ? cbd_pkg::PH_SIZE_LF : cbd_pkg::PH_ERR;
        end else begin
          phase_nxt = cbd_pkg::PH_ERR;
        end
      end
      cbd_pkg::PH_SIZE_LF: begin
        if (data_byte == cbd_pkg::CH_LF) begin
          flags_nxt = 5'd0;
          phase_nxt = (count_r == '0) ? cbd_pkg::PH_FIN_CR : cbd_pkg::PH_DATA;
        end else begin
          phase_nxt = cbd_pkg::PH_ERR;
        end
      end
      cbd_pkg::PH_EXT: begin
        if (data_byte == cbd_pkg::CH_CR) begin
          phase_nxt = cbd_pkg::PH_EXT_CR;
        end
      end
      cbd_pkg::PH_EXT_CR: begin
        if (data_byte == cbd_pkg::CH_LF) begin
          flags_nxt = 5'd0;
          phase_nxt = (count_r == '0) ? cbd_pkg::PH_FIN_CR : cbd_pkg::PH_DATA;
        end else if (data_byte != cbd_pkg::CH_CR) begin
          phase_nxt = cbd_pkg::PH_EXT;
        end
      end
      cbd_pkg::PH_DATA: begin
        res.payload_byte  = data_byte;
        res.payload_valid = 1'b1;
        count_nxt = count_r - SIZE_BITS'(1);
        if (count_r == SIZE_BITS'(1)) begin
          res.chunk_end = 1'b1;
          phase_nxt     = cbd_pkg::PH_DATA_CR;
        end
      end
      cbd_pkg::PH_DATA_CR: begin
        phase_nxt = (data_byte == cbd_pkg::CH_CR) ? cbd_pkg::PH_DATA_LF : cbd_pkg::PH_ERR;
      end
      cbd_pkg::PH_DATA_LF: begin
        if (data_byte == cbd_pkg::CH_LF) begin
          phase_nxt = cbd_pkg::PH_SIZE;
          count_nxt = '0;
          flags_nxt = 5'd0;
        end else begin
          phase_nxt = cbd_pkg::PH_ERR;
        end
      end
      cbd_pkg::PH_FIN_CR: begin
        phase_nxt = (data_byte == cbd_pkg::CH_CR) ? cbd_pkg::PH_FIN_LF : cbd_pkg::PH_ERR;
      end
      cbd_pkg::PH_FIN_LF: begin
        phase_nxt = (data_byte == cbd_pkg::CH_LF) ? cbd_pkg::PH_DONE : cbd_pkg::PH_ERR;
      end
      cbd_pkg::PH_DONE: begin
        phase_nxt = cbd_pkg::PH_DONE;
      end
      default: begin
        phase_nxt = cbd_pkg::PH_ERR;
      end
    endcase
    if (phase_nxt == cbd_pkg::PH_DONE) begin
      res.status = cbd_pkg::ST_DONE;
    end else if (phase_nxt == cbd_pkg::PH_ERR) begin
      res.status = cbd_pkg::ST_ERROR;
    end else begin
      res.status = cbd_pkg::ST_BUSY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cbd_pkg::PH_SIZE;
      count_r <= '0;
      flags_r <= 5'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      flags_r <= flags_nxt;
    end
  end

  `CBD_ASSERT_NEXT(a_err_sticky, clk, rst_n, phase_r == cbd_pkg::PH_ERR, phase_r == cbd_pkg::PH_ERR)
  `CBD_ASSERT_NEXT(a_done_sticky, clk, rst_n, phase_r == cbd_pkg::PH_DONE, phase_r == cbd_pkg::PH_DONE)
  `CBD_ASSERT_IMP(a_end_is_payload, clk, rst_n, res.chunk_end, res.payload_valid && (res.status == cbd_pkg::ST_BUSY))
  `CBD_ASSERT_IMP(a_data_count, clk, rst_n, phase_r == cbd_pkg::PH_DATA, count_r != '0)

endmodule

### design/cbd_out_buf.sv
// Output register with one skid entry for the decoder's result beats.
// Depends on cbd_pkg and chunked_body_decoder_macros.svh.
`include "chunked_body_decoder_macros.svh"

module cbd_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  cbd_pkg::cbd_result_t push_res,
  output logic                 can_push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cbd_pkg::cbd_result_t out_res
);

  logic                 out_valid_r, out_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  cbd_pkg::cbd_result_t out_res_r, out_res_nxt;
  cbd_pkg::cbd_result_t skid_res_r, skid_res_nxt;

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_res_nxt   = push_res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  `CBD_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `CBD_ASSERT_NEXT(a_skid_only_on_stall, clk, rst_n, !skid_valid_r && push && out_valid_r && !out_ready, skid_valid_r && (skid_res_r == $past(push_res)))

endmodule

### dv/chunked_body_decoder_tb.sv
// Self-checking testbench for chunked_body_decoder: a directed table, then one long random
// chunked body closed by a randomly chosen clean or malformed ending, under varied idling.
// Depends on cbd_pkg and the chunked_body_decoder RTL only.
module chunked_body_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbd_pkg::*;

  localparam int SIZE_BITS = 32;
  localparam int HALF_PERIOD = 6;
  localparam int CYCLE_LIMIT = 100000;
  localparam int BODY_TARGET = 1080;

  typedef struct packed {
    logic [7:0]  b;
    logic        typed;
    cbd_result_t res;
  } stim_t;

  typedef enum int {
    END_CLEAN, END_MINUS, END_BLANKS_ONLY, END_SIGN_ONLY, END_PREFIX_ONLY, END_OVERFLOW,
    END_STRAY, END_INNER_BLANK, END_LONE_LF, END_CR_NO_LF, END_DATA_NO_CR, END_DATA_NO_LF,
    END_TRAILER, END_FIN_NO_LF, END_BAD_PREFIX, END_EXTRA_SIGN
  } ending_t;

  localparam cbd_result_t BUSY_RES = '{8'h00, 1'b0, 1'b0, ST_BUSY};

  localparam stim_t DIRECTED [27] = '{
    '{CH_SP,   1'b1, BUSY_RES},
    '{CH_TAB,  1'b0, '0},
    '{CH_PLUS, 1'b0, '0},
    '{"0",     1'b0, '0},
    '{CH_XL,   1'b0, '0},
    '{"0",     1'b0, '0},
    '{"2",     1'b0, '0},
    '{CH_SP,   1'b0, '0},
    '{CH_SEMI, 1'b0, '0},
    '{"a",     1'b0, '0},
    '{CH_CR,   1'b0, '0},
    '{"q",     1'b0, '0},
    '{CH_CR,   1'b0, '0},
    '{CH_CR,   1'b0, '0},
    '{CH_LF,   1'b0, '0},
    '{8'h00,   1'b1, '{8'h00, 1'b1, 1'b0, ST_BUSY}},
    '{8'hFF,   1'b1, '{8'hFF, 1'b1, 1'b1, ST_BUSY}},
    '{CH_CR,   1'b0, '0},
    '{CH_LF,   1'b0, '0},
    '{"0",     1'b0, '0},
    '{CH_XU,   1'b0, '0},
    '{"1",     1'b0, '0},
    '{CH_CR,   1'b0, '0},
    '{CH_LF,   1'b0, '0},
    '{8'h5A,   1'b0, '0},
    '{CH_CR,   1'b0, '0},
    '{CH_LF,   1'b0, '0}
  };

  localparam int IDLE_OF [4]  = '{0, 62, 0, 17};
  localparam int STALL_OF [4] = '{0, 0, 62, 17};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [2:0] out_tuser;

  logic [3:0]  body_phase = PH_SIZE;
  logic [63:0] size_left = '0;
  logic [4:0]  line_flags = '0;

  stim_t       body_q[$];
  stim_t       pending_bytes[$];
  cbd_result_t decoded_q[$];

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          errors = 0;
  int          results_seen = 0;
  int          payload_seen = 0;
  int          chunks_seen = 0;
  logic [1:0]  last_status = ST_BUSY;
  int unsigned cycle_count = 0;
  ending_t     ending;

  chunked_body_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void close_size_line();
    line_flags = '0;
    body_phase = (size_left == 0) ? PH_FIN_CR : PH_DATA;
  endfunction

  function automatic logic [3:0] parse_size_char(input logic [7:0] c);
    logic [4:0] f;
    logic       is_hex;
    logic [3:0] nib;
    f = line_flags;
    is_hex = 1'b1;
    nib = c[3:0];
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      nib = c[3:0] + 4'd9;
    end else if (!(c >= "0" && c <= "9")) begin
      is_hex = 1'b0;
    end
    if (c == CH_SP || c == CH_TAB) begin
      if (!f[FL_SIGN] && !f[FL_DIGIT] && !f[FL_PREFIX]) return PH_SIZE;
      if (!f[FL_DIGIT]) return PH_ERR;
      line_flags[FL_TRAIL] = 1'b1;
      return PH_SIZE;
    end
    if (c == CH_PLUS) begin
      if (f != '0) return PH_ERR;
      line_flags = '0;
      line_flags[FL_SIGN] = 1'b1;
      return PH_SIZE;
    end
    if (is_hex) begin
      if (f[FL_TRAIL] || (size_left >> (SIZE_BITS - 4)) != 0) return PH_ERR;
      size_left = {size_left[59:0], nib};
      f[FL_ZERO] = !f[FL_DIGIT] && !f[FL_PREFIX] && nib == 4'd0;
      f[FL_DIGIT] = 1'b1;
      f[FL_PREFIX] = 1'b0;
      line_flags = f;
      return PH_SIZE;
    end
    if (c == CH_XL || c == CH_XU) begin
      if (!f[FL_ZERO] || f[FL_TRAIL]) return PH_ERR;
      f[FL_ZERO] = 1'b0;
      f[FL_DIGIT] = 1'b0;
      f[FL_PREFIX] = 1'b1;
      line_flags = f;
      return PH_SIZE;
    end
    if (c == CH_SEMI) return f[FL_DIGIT] ? PH_EXT : PH_ERR;
    if (c == CH_CR) return f[FL_DIGIT] ? PH_SIZE_LF : PH_ERR;
    return PH_ERR;
  endfunction

  function automatic cbd_result_t decode_byte(input logic [7:0] c);
    cbd_result_t r;
    r = '0;
    case (body_phase)
      PH_SIZE: body_phase = parse_size_char(c);
      PH_SIZE_LF: begin
        if (c == CH_LF) close_size_line();
        else body_phase = PH_ERR;
      end
      PH_EXT: begin
        if (c == CH_CR) body_phase = PH_EXT_CR;
      end
      PH_EXT_CR: begin
        if (c == CH_LF) close_size_line();
        else if (c != CH_CR) body_phase = PH_EXT;
      end
      PH_DATA: begin
        r.payload_byte = c;
        r.payload_valid = 1'b1;
        size_left = size_left - 1;
        if (size_left == 0) begin
          r.chunk_end = 1'b1;
          body_phase = PH_DATA_CR;
        end
      end
      PH_DATA_CR: body_phase = (c == CH_CR) ? PH_DATA_LF : PH_ERR;
      PH_DATA_LF: begin
        if (c == CH_LF) begin
          body_phase = PH_SIZE;
          size_left = '0;
          line_flags = '0;
        end else begin
          body_phase = PH_ERR;
        end
      end
      PH_FIN_CR: body_phase = (c == CH_CR) ? PH_FIN_LF : PH_ERR;
      PH_FIN_LF: body_phase = (c == CH_LF) ? PH_DONE : PH_ERR;
      PH_DONE: ;
      default: body_phase = PH_ERR;
    endcase
    if (body_phase == PH_DONE) r.status = ST_DONE;
    else if (body_phase == PH_ERR) r.status = ST_ERROR;
    else r.status = ST_BUSY;
    return r;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    body_q.push_back('{b, 1'b0, '0});
  endtask

  task automatic put_digit(input int unsigned d);
    if (d < 10) put_byte(8'("0" + d));
    else put_byte(8'(($urandom_range(1) ? "a" : "A") + d - 10));
  endtask

  task automatic put_hex(input int unsigned v);
    int nd;
    nd = 1;
    while (nd < 8 && (v >> (4 * nd)) != 0) nd++;
    for (int i = nd - 1; i >= 0; i--) put_digit((v >> (4 * i)) & 15);
  endtask

  task automatic put_blanks(input int n);
    repeat (n) put_byte($urandom_range(1) ? CH_SP : CH_TAB);
  endtask

  task automatic put_size_line(input int unsigned sz);
    int unsigned form;
    logic [7:0]  prev;
    logic [7:0]  b;
    if ($urandom_range(3) == 0) put_blanks($urandom_range(1, 2));
    if ($urandom_range(4) == 0) put_byte(CH_PLUS);
    form = $urandom_range(5);
    if (form == 0) begin
      put_byte("0");
      put_byte($urandom_range(1) ? CH_XL : CH_XU);
    end else if (form == 1) begin
      repeat ($urandom_range(1, 12)) put_byte("0");
    end
    put_hex(sz);
    if ($urandom_range(4) == 0) put_blanks($urandom_range(1, 2));
    if ($urandom_range(3) == 0) begin
      put_byte(CH_SEMI);
      prev = CH_SEMI;
      repeat ($urandom_range(0, 6)) begin
        b = ($urandom_range(5) == 0) ? CH_CR : 8'($urandom_range(255));
        if (prev == CH_CR && b == CH_LF) b = CH_CR;
        put_byte(b);
        prev = b;
      end
    end
    put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding", cycle_count,
               decoded_q.size() + pending_bytes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    stim_t       sent;
    cbd_result_t predicted;
    cbd_result_t wanted;
    cbd_result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sent = pending_bytes.pop_front();
        predicted = decode_byte(sent.b);
        decoded_q.push_back(sent.typed ? sent.res : predicted);
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata, out_tuser[0], out_tlast, out_tuser[2:1]};
        results_seen++;
        last_status = got.status;
        if (got.payload_valid) payload_seen++;
        if (got.chunk_end) chunks_seen++;
        if (decoded_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Unexpected result beat: data %h valid %b last %b status %0d",
                     got.payload_byte, got.payload_valid, got.chunk_end, got.status);
        end else begin
          wanted = decoded_q.pop_front();
          if (got.payload_byte !== wanted.payload_byte ||
              got.payload_valid !== wanted.payload_valid ||
              got.chunk_end !== wanted.chunk_end || got.status !== wanted.status) begin
            errors++;
            if (errors <= 10)
              $display({"Mismatch on result beat %0d: expected data %h valid %b last %b ",
                        "status %0d, got data %h valid %b last %b status %0d"},
                       results_seen, wanted.payload_byte, wanted.payload_valid,
                       wanted.chunk_end, wanted.status, got.payload_byte,
                       got.payload_valid, got.chunk_end, got.status);
          end
        end
      end
    end
  end

  initial begin
    int          nrand;
    int          ph;
    int          cur_ph;
    int unsigned sz;
    int unsigned r;
    logic [7:0]  b;

    foreach (DIRECTED[i]) body_q.push_back(DIRECTED[i]);
    while (body_q.size() < BODY_TARGET) begin
      r = $urandom_range(99);
      if (r < 70) sz = $urandom_range(1, 8);
      else if (r < 95) sz = $urandom_range(9, 40);
      else sz = $urandom_range(41, 200);
      put_size_line(sz);
      repeat (sz) put_byte(8'($urandom_range(255)));
      put_byte(CH_CR);
      put_byte(CH_LF);
    end

    ending = ending_t'($urandom_range(END_EXTRA_SIGN));
    case (ending)
      END_CLEAN: begin
        put_size_line(0);
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
      END_MINUS: begin
        put_blanks($urandom_range(0, 1));
        put_byte("-");
        put_hex($urandom_range(1, 255));
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
      END_BLANKS_ONLY: begin
        put_blanks($urandom_range(1, 3));
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
      END_SIGN_ONLY: begin
        put_byte(CH_PLUS);
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
      END_PREFIX_ONLY: begin
        put_byte("0");
        put_byte($urandom_range(1) ? CH_XL : CH_XU);
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
      END_OVERFLOW: begin
        put_digit($urandom_range(1, 15));
        repeat (8) put_digit($urandom_range(15));
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
      END_STRAY: begin
        put_hex($urandom_range(1, 255));
        do b = 8'($urandom_range(255));
        while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F") ||
               b == CH_SP || b == CH_TAB || b == CH_PLUS || b == CH_SEMI || b == CH_CR ||
               b == CH_XL || b == CH_XU);
        put_byte(b);
      end
      END_INNER_BLANK: begin
        put_hex($urandom_range(1, 15));
        put_byte(CH_SP);
        put_hex($urandom_range(1, 15));
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
      END_LONE_LF: begin
        put_hex($urandom_range(1, 255));
        put_byte(CH_LF);
      end
      END_CR_NO_LF: begin
        put_hex($urandom_range(1, 255));
        put_byte(CH_CR);
        put_byte("A");
      end
      END_DATA_NO_CR: begin
        put_size_line(2);
        repeat (2) put_byte(8'($urandom_range(255)));
        put_byte("A");
      end
      END_DATA_NO_LF: begin
        put_size_line(1);
        put_byte(8'($urandom_range(255)));
        put_byte(CH_CR);
        put_byte(CH_CR);
      end
      END_TRAILER: begin
        put_size_line(0);
        put_byte("X");
        put_byte(":");
        put_byte(CH_SP);
        put_byte("1");
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
      END_FIN_NO_LF: begin
        put_size_line(0);
        put_byte(CH_CR);
        put_byte("A");
      end
      END_BAD_PREFIX: begin
        put_hex($urandom_range(1, 15));
        put_byte(CH_XL);
      end
      default: begin
        put_byte(CH_PLUS);
        put_byte(CH_PLUS);
        put_byte("1");
      end
    endcase
    repeat ($urandom_range(16, 40)) put_byte(8'($urandom_range(255)));

    nrand = body_q.size() - $size(DIRECTED);
    cur_ph = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < body_q.size(); i++) begin
      ph = (i < $size(DIRECTED)) ? 0 : ((i - $size(DIRECTED)) * 4) / nrand;
      if (ph != cur_ph) begin
        in_tvalid <= 1'b0;
        wait (pending_bytes.size() == 0 && decoded_q.size() == 0);
        @(posedge clk);
        cur_ph = ph;
        idle_pct = IDLE_OF[ph];
        stall_pct <= STALL_OF[ph];
      end
      while ($urandom_range(99) < idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      pending_bytes.push_back(body_q[i]);
      in_tvalid <= 1'b1;
      in_tdata <= body_q[i].b;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 1'b0;

    wait (pending_bytes.size() == 0 && decoded_q.size() == 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d body bytes and checked %0d result beats: %0d payload bytes, %0d chunks.",
             body_q.size(), results_seen, payload_seen, chunks_seen);
    $display("The body closed with case %s and final status %0d, under four idling settings.",
             ending.name(), last_status);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatching result beats", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/cbd_pkg.sv
design/cbd_core.sv
design/cbd_out_buf.sv
design/chunked_body_decoder.sv
dv/chunked_body_decoder_tb.sv
